/* rtl/sssp_pkg.sv */
// Shared types, constants and helpers for the single-source shortest path block.
// Used by the edge store, the top level and the port checker.
package sssp_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic signed [31:0] DIST_INF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
  localparam logic [5:0]         PRED_NONE = 6'h3F;

  // Configuration register indexes.
  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  localparam logic [5:0] VERTEX_COUNT_RST  = 6'd32;
  localparam logic [4:0] SOURCE_VERTEX_RST = 5'd0;

  // One entry of the per-vertex path memory.
  typedef struct packed {
    logic              reached;
    logic signed [31:0] dist_val;
    logic [5:0]         pred;
  } dist_entry_t;

  // Signed add that saturates to the 32-bit range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? DIST_MIN : DIST_INF;
    end
    return s[31:0];
  endfunction

endpackage

/* rtl/sssp_edge_store.sv */
// Adjacency matrix memory: one present bit and a weight per (tail, head) pair.
// Runs a clearing pass after reset. Depends on sssp_pkg for nothing but defaults.
module sssp_edge_store #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF,
  parameter int DEPTH        = MAX_VERTICES * MAX_VERTICES,
  parameter int EW           = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [EW-1:0]        wr_addr,
  input  logic [WEIGHT_BITS:0] wr_data,
  input  logic [EW-1:0]        rd_addr,
  output logic [WEIGHT_BITS:0] rd_data,
  output logic                 ready
);
  import sssp_pkg::*;

  logic [WEIGHT_BITS:0] mem [DEPTH];
  logic [EW:0]          clr_cnt;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (EW+1)'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  // Entry layout: present bit on top, weight below.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[EW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign ready = !busy;

endmodule

/* rtl/single_source_shortest_path_top.sv */
// Bellman-Ford shortest paths over a stored adjacency matrix. An edge beat
// (tuser 0) writes one matrix entry. A run beat (tuser 1) holds s_tready
// low while it works: it clears the path memory, then in each pass visits
// every tail and sweeps the matrix row of every reached tail, for up to
// n-1 passes plus one check pass, then emits one result beat per vertex
// (n = vertex count, clamped to 1..MAX_VERTICES). After reset every entry
// of the edge memory is cleared before the first beat is taken. Depends
// on sssp_pkg and sssp_edge_store.
module single_source_shortest_path_top #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] from_vertex, [9:5] to_vertex, [25:10] edge_weight, [26] edge_present
  input  logic [31:0] s_tdata,
  // [0] func
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] vertex, [36:5] distance, [37] reachable, [43:38] predecessor,
  // [44] negative_cycle
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import sssp_pkg::*;

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int EW    = $clog2(DEPTH);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);

  typedef enum logic [8:0] {
    ST_INIT    = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_CLR     = 9'b000000100,
    ST_TAIL    = 9'b000001000,
    ST_LOAD    = 9'b000010000,
    ST_ROW     = 9'b000100000,
    ST_DRAIN   = 9'b001000000,
    ST_EMIT_RD = 9'b010000000,
    ST_EMIT_LD = 9'b100000000
  } state_t;

  state_t state;

  logic [5:0] vertex_count;
  logic [4:0] source_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RST;
      source_vertex <= SOURCE_VERTEX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        CFG_SOURCE_VERTEX: source_vertex <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [4:0]             in_from;
  logic [4:0]             in_to;
  logic [15:0]            in_weight;
  logic                   in_present;
  logic                   s_beat;
  assign in_from    = s_tdata[4:0];
  assign in_to      = s_tdata[9:5];
  assign in_weight  = s_tdata[25:10];
  assign in_present = s_tdata[26];
  assign s_tready   = (state == ST_IDLE);
  assign s_beat     = s_tvalid && s_tready;

  // Run control registers.
  logic [CW-1:0] n;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] pass;
  logic [VW-1:0] u, v, k;
  logic          check, changed, neg;
  logic signed [31:0] du;
  logic          p1_valid;
  logic [VW-1:0] p1_v;

  always_comb begin
    if (vertex_count == '0) n_eff = CW'(1);
    else if (int'(vertex_count) > MAX_VERTICES) n_eff = CW'(MAX_VERTICES);
    else n_eff = CW'(vertex_count);
  end

  // Edge memory.
  logic                 edge_ready;
  logic                 edge_we;
  logic [EW-1:0]        edge_waddr;
  logic [EW-1:0]        edge_raddr;
  logic [WEIGHT_BITS:0] edge_q;

  assign edge_we = s_beat && !s_tuser && (int'(in_from) < MAX_VERTICES)
                   && (int'(in_to) < MAX_VERTICES);
  assign edge_waddr = EW'(int'(in_from) * MAX_VERTICES + int'(in_to));
  assign edge_raddr = EW'(int'(u) * MAX_VERTICES + int'(v));

  sssp_edge_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_edge_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (edge_we),
    .wr_addr(edge_waddr),
    .wr_data({in_present, in_present ? in_weight[WEIGHT_BITS-1:0] : WEIGHT_BITS'(0)}),
    .rd_addr(edge_raddr),
    .rd_data(edge_q),
    .ready  (edge_ready)
  );

  // Path memory: one entry per vertex, read every cycle and written at most once per cycle.
  dist_entry_t   dmem [MAX_VERTICES];
  dist_entry_t   dq;
  dist_entry_t   dwdata;
  logic [VW-1:0] draddr, dwaddr;
  logic          dwe;

  logic signed [31:0] wext, cand;
  logic               relax, changed_now, src_ok;

  assign wext  = 32'(signed'(edge_q[WEIGHT_BITS-1:0]));
  assign cand  = sat_add(du, wext);
  assign relax = p1_valid && edge_q[WEIGHT_BITS] && (!dq.reached || cand < dq.dist_val);
  assign changed_now = changed || relax;
  assign src_ok = (CW'(source_vertex) < n) && (int'(source_vertex) < MAX_VERTICES);

  always_comb begin
    priority if (state == ST_TAIL) draddr = u;
    else if (state == ST_ROW) draddr = v;
    else draddr = k;
  end

  always_comb begin
    if (state == ST_CLR) begin
      dwe    = 1'b1;
      dwaddr = k;
      if (src_ok && int'(k) == int'(source_vertex)) dwdata = '{1'b1, 32'sd0, PRED_NONE};
      else dwdata = '{1'b0, DIST_INF, PRED_NONE};
    end else begin
      dwe    = relax && !check;
      dwaddr = p1_v;
      dwdata = '{1'b1, cand, 6'(u)};
    end
  end

  always_ff @(posedge clk) begin
    if (dwe) dmem[dwaddr] <= dwdata;
    dq <= dmem[draddr];
  end

  // Output register.
  logic [4:0]         o_vertex;
  logic signed [31:0] o_dist;
  logic               o_reach;
  logic [5:0]         o_pred;
  logic               o_neg;

  assign m_tdata = {3'b000, o_neg, o_pred, o_reach, o_dist, o_vertex};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      m_tvalid <= 1'b0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_ROW);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_INIT: if (edge_ready) state <= ST_IDLE;
        ST_IDLE: begin
          if (s_beat && s_tuser) begin
            n     <= n_eff;
            k     <= '0;
            neg   <= 1'b0;
            state <= ST_CLR;
          end
        end
        ST_CLR: begin
          if (CW'(k) == n - 1'b1) begin
            k <= '0;
            if (!src_ok) begin
              state <= ST_EMIT_RD;
            end else begin
              u       <= '0;
              changed <= 1'b0;
              pass    <= CW'(1);
              check   <= (n == CW'(1));
              state   <= ST_TAIL;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_TAIL: state <= ST_LOAD;
        ST_LOAD: begin
          du <= dq.dist_val;
          v  <= '0;
          state <= dq.reached ? ST_ROW : ST_DRAIN;
        end
        ST_ROW: begin
          p1_v <= v;
          if (CW'(v) == n - 1'b1) state <= ST_DRAIN;
          else v <= v + 1'b1;
        end
        ST_DRAIN: begin
          if (CW'(u) != n - 1'b1) begin
            u     <= u + 1'b1;
            state <= ST_TAIL;
          end else if (check) begin
            neg   <= changed_now;
            state <= ST_EMIT_RD;
          end else if (!changed_now) begin
            state <= ST_EMIT_RD;
          end else begin
            u     <= '0;
            state <= ST_TAIL;
            if (pass == n - 1'b1) check <= 1'b1;
            else pass <= pass + 1'b1;
          end
        end
        ST_EMIT_RD: if (!m_tvalid || m_tready) state <= ST_EMIT_LD;
        ST_EMIT_LD: begin
          m_tvalid <= 1'b1;
          o_vertex <= 5'(k);
          o_dist   <= dq.dist_val;
          o_reach  <= dq.reached;
          o_pred   <= dq.pred;
          o_neg    <= neg;
          m_tlast  <= (CW'(k) == n - 1'b1);
          if (CW'(k) == n - 1'b1) begin
            state <= ST_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= ST_EMIT_RD;
          end
        end
        default: state <= ST_INIT;
      endcase
      // Relaxation bookkeeping runs alongside the sequencer.
      if (state == ST_DRAIN && CW'(u) == n - 1'b1) changed <= 1'b0;
      else if (relax) changed <= 1'b1;
      if (relax && !check && p1_v == u) du <= cand;
    end
  end

endmodule

/* rtl/sssp_checker.sv */
// Port-level checks for the shortest path block, bound to its top level.
// Depends on sssp_pkg for the infinity and no-predecessor codes.
module sssp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  import sssp_pkg::*;

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // The edge memory is being cleared right after reset.
  a_init_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during edge memory clearing");

  // A run beat blocks the input while the sweep runs.
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken right after a run beat");

  // An unreached vertex reports infinity and no predecessor.
  a_unreached: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[37] |-> m_tdata[36:5] == DIST_INF && m_tdata[43:38] == PRED_NONE)
    else $error("unreached vertex with a finite result");

endmodule

bind single_source_shortest_path_top sssp_checker u_sssp_checker (.*);
